// File: rtl/qmn_pkg.sv
// Shared types and constants for the quaternion multiply and normalize block.
package qmn_pkg;

	// operation codes carried on the input tuser
	localparam logic [1:0] OP_MUL  = 2'd0;
	localparam logic [1:0] OP_CONJ = 2'd1;

	// configuration registers
	localparam int TOL_W  = 40;
	localparam int SNAP_W = 10;
	localparam logic REG_TOL  = 1'b0;
	localparam logic REG_SNAP = 1'b1;
	localparam logic [TOL_W-1:0]  TOL_RESET  = 40'd1152922;
	localparam logic [SNAP_W-1:0] SNAP_RESET = 10'd1;

	// tolerance is given in units of 2^-60
	localparam int TOL_SHIFT = 60;

	// Hamilton product: term t of component k is a[t] * b[k ^ t];
	// bit t of row k set means the term is subtracted
	localparam logic [3:0][3:0] HAM_SUB = {4'b0100, 4'b0010, 4'b1000, 4'b1110};

	// per-item control passed from the front to the back
	typedef struct packed {
		logic [3:0] neg;
		logic       rescale;
		logic       degenerate;
	} ctl_t;

endpackage

// File: rtl/qmn_front.sv
// Front pipeline: exact product, magnitude squared and tolerance classification.
module qmn_front #(
	parameter int W = 32,
	localparam int F   = W - 2,
	localparam int CSW = 2 * W + 2,
	localparam int CMW = 2 * W + 1,
	localparam int SQW = 4 * W + 2,
	localparam int MW  = 4 * W + 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 in_op,
	input  logic [8*W-1:0]             in_data,
	input  logic [qmn_pkg::TOL_W-1:0]  tol,
	output logic                       out_valid,
	input  logic                       out_ready,
	output qmn_pkg::ctl_t              out_ctl,
	output logic [MW-1:0]              out_m,
	output logic [3:0][SQW-1:0]        out_sq,
	output logic [3:0][W-1:0]          out_low
);

	localparam int SH_UP = (4 * F >= qmn_pkg::TOL_SHIFT) ? 4 * F - qmn_pkg::TOL_SHIFT : 0;
	localparam int SH_DN = (4 * F <  qmn_pkg::TOL_SHIFT) ? qmn_pkg::TOL_SHIFT - 4 * F : 0;
	localparam int CPW   = MW + qmn_pkg::TOL_SHIFT + qmn_pkg::TOL_W;
	localparam logic [MW-1:0] ONE = MW'(1) << (4 * F);

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;

	logic signed [W-1:0]     in_a [4];
	logic signed [W-1:0]     in_b [4];
	logic signed [W-1:0]     a_s1 [4];
	logic signed [2*W-1:0]   prod_s1 [4][4];
	logic [1:0]              op_s1;
	logic signed [CSW-1:0]   c_d [4];
	logic signed [CSW-1:0]   c_s2 [4];
	logic [CMW-1:0]          cm_s3 [4];
	logic [3:0]              neg_s3, neg_s4, neg_s5, neg_s6, neg_s7, neg_s8, neg_s9;
	logic [2*W+1:0]          hh_s4 [4];
	logic [2*W:0]            hl_s4 [4];
	logic [2*W-1:0]          ll_s4 [4];
	logic [3:0][W-1:0]       low_s4, low_s5, low_s6, low_s7, low_s8, low_s9;
	logic [3:0][SQW-1:0]     sq_s5, sq_s6, sq_s7, sq_s8, sq_s9;
	logic [MW-1:0]           m01_s6, m23_s6, m_s7, m_s8, m_s9, dev_s8;
	logic                    deg_s8, deg_s9, resc_s9;

	// whole pipeline moves unless the last stage is blocked
	assign en       = !v_s9 || out_ready;
	assign in_ready = en;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			in_a[k] = in_data[k*W +: W];
			in_b[k] = in_data[(4+k)*W +: W];
		end
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9} <= '0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	// stage 2 sum: Hamilton terms, or a (conjugated for OP_CONJ) scaled to 2F fraction bits
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			c_d[k] = '0;
			case (op_s1)
				qmn_pkg::OP_MUL: begin
					for (int t = 0; t < 4; t++) begin
						if (qmn_pkg::HAM_SUB[k][t])
							c_d[k] = c_d[k] - CSW'(prod_s1[k][t]);
						else
							c_d[k] = c_d[k] + CSW'(prod_s1[k][t]);
					end
				end
				qmn_pkg::OP_CONJ: begin
					if (k != 0)
						c_d[k] = -(CSW'(a_s1[k]) <<< F);
					else
						c_d[k] = CSW'(a_s1[k]) <<< F;
				end
				default: begin
					c_d[k] = CSW'(a_s1[k]) <<< F;
				end
			endcase
		end
	end

	// datapath stages
	always_ff @(posedge clk) begin
		if (en) begin
			// s1: partial products
			op_s1 <= in_op;
			for (int k = 0; k < 4; k++) begin
				a_s1[k] <= in_a[k];
				for (int t = 0; t < 4; t++)
					prod_s1[k][t] <= (2*W)'(in_a[t]) * (2*W)'(in_b[k ^ t]);
			end
			// s2: exact components
			for (int k = 0; k < 4; k++)
				c_s2[k] <= c_d[k];
			// s3: sign and magnitude
			for (int k = 0; k < 4; k++) begin
				neg_s3[k] <= c_s2[k][CSW-1];
				cm_s3[k]  <= c_s2[k][CSW-1] ? CMW'(-c_s2[k]) : CMW'(c_s2[k]);
			end
			// s4: square split into three narrower products
			for (int k = 0; k < 4; k++) begin
				hh_s4[k]  <= (2*W+2)'(cm_s3[k][CMW-1:W]) * (2*W+2)'(cm_s3[k][CMW-1:W]);
				hl_s4[k]  <= (2*W+1)'(cm_s3[k][CMW-1:W]) * (2*W+1)'(cm_s3[k][W-1:0]);
				ll_s4[k]  <= (2*W)'(cm_s3[k][W-1:0]) * (2*W)'(cm_s3[k][W-1:0]);
				low_s4[k] <= cm_s3[k][F +: W];
			end
			neg_s4 <= neg_s3;
			// s5: squares
			for (int k = 0; k < 4; k++)
				sq_s5[k] <= (SQW'(hh_s4[k]) << (2 * W)) + (SQW'(hl_s4[k]) << (W + 1))
					+ SQW'(ll_s4[k]);
			neg_s5 <= neg_s4;
			low_s5 <= low_s4;
			// s6, s7: magnitude squared
			m01_s6 <= MW'(sq_s5[0]) + MW'(sq_s5[1]);
			m23_s6 <= MW'(sq_s5[2]) + MW'(sq_s5[3]);
			neg_s6 <= neg_s5;
			low_s6 <= low_s5;
			sq_s6  <= sq_s5;
			m_s7   <= m01_s6 + m23_s6;
			neg_s7 <= neg_s6;
			low_s7 <= low_s6;
			sq_s7  <= sq_s6;
			// s8: deviation from one
			dev_s8 <= (m_s7 >= ONE) ? m_s7 - ONE : ONE - m_s7;
			deg_s8 <= (m_s7 == '0);
			m_s8   <= m_s7;
			neg_s8 <= neg_s7;
			low_s8 <= low_s7;
			sq_s8  <= sq_s7;
			// s9: tolerance test
			resc_s9 <= (CPW'(dev_s8) << SH_DN) > (CPW'(tol) << SH_UP);
			deg_s9  <= deg_s8;
			m_s9    <= m_s8;
			neg_s9  <= neg_s8;
			low_s9  <= low_s8;
			sq_s9   <= sq_s8;
		end
	end

	assign out_valid = v_s9;
	assign out_m     = m_s9;
	assign out_sq    = sq_s9;
	assign out_low   = low_s9;

	always_comb begin
		out_ctl.neg        = neg_s9;
		out_ctl.rescale    = resc_s9;
		out_ctl.degenerate = deg_s9;
	end

endmodule

// File: rtl/qmn_fifo.sv
// Two-entry queue between the front pipeline and the back sequencer.
module qmn_fifo #(
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [DW-1:0] in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [DW-1:0] out_data
);

	localparam int DEPTH = 2;
	localparam int PW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	logic [DW-1:0] mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          push, pop;

	assign in_ready  = cnt_q != CW'(DEPTH);
	assign out_valid = cnt_q != '0;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_data  = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + CW'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CW'(1);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= in_data;
	end

endmodule

// File: rtl/qmn_back.sv
// Back sequencer: per-lane bit-serial divide and square root, output register.
module qmn_back #(
	parameter int W = 32,
	localparam int F   = W - 2,
	localparam int SQW = 4 * W + 2,
	localparam int MW  = 4 * W + 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  qmn_pkg::ctl_t               in_ctl,
	input  logic [MW-1:0]               in_m,
	input  logic [3:0][SQW-1:0]         in_sq,
	input  logic [3:0][W-1:0]           in_low,
	input  logic [qmn_pkg::SNAP_W-1:0]  snap,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [4*W-1:0]              out_data,
	output logic [1:0]                  out_user
);

	localparam int RMW  = MW + 1;
	localparam int QW   = 2 * F + 2;
	localparam int RW   = F + 1;
	localparam int SRW  = F + 4;
	localparam int CNTW = $clog2(2 * F + 1);
	localparam int SNPW = (RW > qmn_pkg::SNAP_W) ? RW : qmn_pkg::SNAP_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_ROOT,
		ST_DONE
	} state_t;

	state_t            state_q;
	logic [CNTW-1:0]   cnt_q;
	logic              out_valid_q;
	logic [4*W-1:0]    out_data_q;
	logic [1:0]        out_user_q;

	logic [MW-1:0]     m_q;
	logic [RMW-1:0]    rem_q [4];
	logic [QW-1:0]     quo_q [4];
	logic [SRW-1:0]    srem_q [4];
	logic [RW-1:0]     root_q [4];
	logic [3:0][W-1:0] low_q;
	logic [3:0]        neg_q;
	logic              resc_q, deg_q;

	logic [RMW-1:0]    rem_sub [4];
	logic [RMW-1:0]    rem_d [4];
	logic [3:0]        div_ge;
	logic [SRW-1:0]    r2_d [4];
	logic [SRW-1:0]    trial_d [4];
	logic [SRW-1:0]    srem_d [4];
	logic [3:0]        rt_ge;
	logic [W-1:0]      mag_d [4];
	logic [3:0][W-1:0] res_d;

	assign in_ready = (state_q == ST_IDLE);

	// one quotient bit and one root bit per lane per cycle
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			div_ge[k]  = rem_q[k] >= {1'b0, m_q};
			rem_sub[k] = div_ge[k] ? rem_q[k] - {1'b0, m_q} : rem_q[k];
			rem_d[k]   = rem_sub[k] << 1;
			r2_d[k]    = {srem_q[k][SRW-3:0], quo_q[k][QW-1 -: 2]};
			trial_d[k] = SRW'({root_q[k], 2'b01});
			rt_ge[k]   = r2_d[k] >= trial_d[k];
			srem_d[k]  = rt_ge[k] ? r2_d[k] - trial_d[k] : r2_d[k];
		end
	end

	// final magnitudes, zero snap on the scalar, sign restore
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			if (deg_q)
				mag_d[k] = '0;
			else if (resc_q)
				mag_d[k] = W'(root_q[k]);
			else
				mag_d[k] = low_q[k];
		end
		if (resc_q && (SNPW'(root_q[0]) <= SNPW'(snap)))
			mag_d[0] = '0;
		for (int k = 0; k < 4; k++)
			res_d[k] = neg_q[k] ? (W'(0) - mag_d[k]) : mag_d[k];
	end

	// lane registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			m_q    <= in_m;
			low_q  <= in_low;
			neg_q  <= in_ctl.neg;
			resc_q <= in_ctl.rescale;
			deg_q  <= in_ctl.degenerate;
			for (int k = 0; k < 4; k++) begin
				rem_q[k]  <= RMW'(in_sq[k]);
				quo_q[k]  <= '0;
				srem_q[k] <= '0;
				root_q[k] <= '0;
			end
		end else if (state_q == ST_DIV) begin
			for (int k = 0; k < 4; k++) begin
				rem_q[k] <= rem_d[k];
				quo_q[k] <= {quo_q[k][QW-2:0], div_ge[k]};
			end
		end else if (state_q == ST_ROOT) begin
			for (int k = 0; k < 4; k++) begin
				srem_q[k] <= srem_d[k];
				root_q[k] <= {root_q[k][RW-2:0], rt_ge[k]};
				quo_q[k]  <= quo_q[k] << 2;
			end
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			out_user_q  <= '0;
		end else begin
			// a result taken while the next one is not yet loaded
			if (out_valid_q && out_ready && state_q != ST_DONE)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cnt_q   <= '0;
						state_q <= (in_ctl.rescale && !in_ctl.degenerate) ? ST_DIV : ST_DONE;
					end
				end
				ST_DIV: begin
					if (cnt_q == CNTW'(2 * F)) begin
						cnt_q   <= '0;
						state_q <= ST_ROOT;
					end else begin
						cnt_q <= cnt_q + CNTW'(1);
					end
				end
				ST_ROOT: begin
					if (cnt_q == CNTW'(F))
						state_q <= ST_DONE;
					else
						cnt_q <= cnt_q + CNTW'(1);
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_data_q  <= res_d;
						out_user_q  <= {deg_q, resc_q && !deg_q};
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_user  = out_user_q;

endmodule

// File: rtl/quaternion_multiply_normalize.sv
// Top level: quaternion product, conjugate or pass-through, then normalization.
//
// Items enter on the s_ stream; tuser picks the operation (multiply a by b,
// conjugate a, normalize a). The front is a nine-stage pipeline that forms the
// exact product, the magnitude squared M and the tolerance decision, and it
// takes a new item every cycle while the two-entry queue behind it has room.
// The back works one item at a time: an item within tolerance, or with zero
// magnitude, goes from the idle state straight to the done state and into the
// output register; an item that must be rescaled first runs four lanes of a
// restoring divider followed by a digit-by-digit square root.
// That serial divide and root sets the sustained rate for rescaled items.
// Results wait in an output register, so the front keeps accepting while the
// sink stalls until its nine stages and the queue are full. Configuration is
// written through cfg_we/cfg_index/cfg_wdata; the user must write it only
// while the block is idle, which the block itself does not enforce.
module quaternion_multiply_normalize #(
	parameter int COMPONENT_WIDTH = 32,
	localparam int W   = COMPONENT_WIDTH,
	localparam int IDW = ((8 * W + 7) / 8) * 8,
	localparam int ODW = ((4 * W + 7) / 8) * 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [IDW-1:0]             s_tdata,   // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z
	input  logic [1:0]                 s_tuser,   // operation
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [ODW-1:0]             m_tdata,   // r_w, r_x, r_y, r_z
	output logic [1:0]                 m_tuser,   // rescaled, degenerate
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [qmn_pkg::TOL_W-1:0]  cfg_wdata
);

	localparam int SQW = 4 * W + 2;
	localparam int MW  = 4 * W + 4;
	localparam int QDW = $bits(qmn_pkg::ctl_t) + MW + 4 * SQW + 4 * W;

	logic [qmn_pkg::TOL_W-1:0]  tol_q;
	logic [qmn_pkg::SNAP_W-1:0] snap_q;

	logic                f_valid, f_ready;
	qmn_pkg::ctl_t       f_ctl;
	logic [MW-1:0]       f_m;
	logic [3:0][SQW-1:0] f_sq;
	logic [3:0][W-1:0]   f_low;

	logic                b_valid, b_ready;
	logic [QDW-1:0]      b_data;
	qmn_pkg::ctl_t       b_ctl;
	logic [MW-1:0]       b_m;
	logic [3:0][SQW-1:0] b_sq;
	logic [3:0][W-1:0]   b_low;
	logic [4*W-1:0]      r_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q  <= qmn_pkg::TOL_RESET;
			snap_q <= qmn_pkg::SNAP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				qmn_pkg::REG_TOL:  tol_q  <= cfg_wdata;
				qmn_pkg::REG_SNAP: snap_q <= cfg_wdata[qmn_pkg::SNAP_W-1:0];
				default: ;
			endcase
		end
	end

	qmn_front #(.W(W)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_op     (s_tuser),
		.in_data   (s_tdata[8*W-1:0]),
		.tol       (tol_q),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.out_ctl   (f_ctl),
		.out_m     (f_m),
		.out_sq    (f_sq),
		.out_low   (f_low)
	);

	qmn_fifo #(.DW(QDW)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_data   ({f_ctl, f_m, f_sq, f_low}),
		.out_valid (b_valid),
		.out_ready (b_ready),
		.out_data  (b_data)
	);

	assign {b_ctl, b_m, b_sq, b_low} = b_data;

	qmn_back #(.W(W)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (b_valid),
		.in_ready  (b_ready),
		.in_ctl    (b_ctl),
		.in_m      (b_m),
		.in_sq     (b_sq),
		.in_low    (b_low),
		.snap      (snap_q),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (r_data),
		.out_user  (m_tuser)
	);

	assign m_tdata = ODW'(r_data);

endmodule

// File: rtl/qmn_checker.sv
// Port-level checks on the result stream, bound to the top level.
module qmn_checker #(
	parameter int W = 32,
	localparam int ODW = ((4 * W + 7) / 8) * 8
) (
	input logic           clk,
	input logic           arst_n,
	input logic           m_tvalid,
	input logic           m_tready,
	input logic [ODW-1:0] m_tdata,
	input logic [1:0]     m_tuser
);

	localparam logic signed [W-1:0] UNIT_P = W'(1) << (W - 2);
	localparam logic signed [W-1:0] UNIT_N = -UNIT_P;

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// zero magnitude gives an all-zero quaternion
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata[4*W-1:0] == '0)
		else $error("degenerate result not zero");

	// the two flags never come together
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("rescaled and degenerate both set");

	// a rescaled scalar part lies within plus or minus one
	a_unit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |->
			($signed(m_tdata[W-1:0]) <= UNIT_P) && ($signed(m_tdata[W-1:0]) >= UNIT_N))
		else $error("rescaled scalar out of range");

endmodule

bind quaternion_multiply_normalize qmn_checker #(.W(COMPONENT_WIDTH)) u_qmn_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
